FILE: rtl/cft_pkg.sv
// shared constants, types and codes of the constant fraction timing block
package cft_pkg;

   localparam int TRACE_LEN = 512;
   localparam int MAX_DELAY = 32;
   localparam int HIST      = 10;
   localparam int EDGE      = 10;
   localparam int SPAN      = 5;

   localparam int SAMPLE_W  = 16;
   localparam int DELAY_W   = 5;
   localparam int ADDR_W    = $clog2(MAX_DELAY);
   localparam int IDX_W     = $clog2(TRACE_LEN + 1);
   localparam int CW        = 34;
   localparam int SW        = CW + 3;
   localparam int DIFF_W    = SW + 2;
   localparam int DEN_W     = SW + 1;
   localparam int QW        = 11;
   localparam int REM_W     = SW + QW;
   localparam int CNT_W     = $clog2(QW);
   localparam int TW        = 17;
   localparam int FRAC_SH   = 14;
   localparam int TIME_SH   = 8;

   typedef enum logic [1:0] {
      CSR_FRACTION  = 2'd0,
      CSR_DELAY     = 2'd1,
      CSR_THRESHOLD = 2'd2
   } cft_csr_type;

   typedef enum logic [1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_NEVER    = 2'd1,
      STATUS_NO_CROSS = 2'd2
   } cft_status_type;

   typedef struct packed {
      logic              start;
      logic [SW-1:0]     mag;
      logic [DEN_W-1:0]  den;
      logic [TW-1:0]     base;
   } cft_div_req_type;

   typedef struct packed {
      logic              busy;
      logic [TW-1:0]     crossing_q8;
   } cft_div_rsp_type;

endpackage

FILE: rtl/cft_req_if.sv
// sample channel: one trace sample per item, last marks the end of the trace
interface cft_req_if;
   import cft_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: rtl/cft_rsp_if.sv
// result channel: one item per trace with status and crossing time
interface cft_rsp_if;
   import cft_pkg::*;
   logic            valid;
   logic            ready;
   logic [1:0]      status;
   logic [TW-1:0]   crossing_time_q8;

   modport source (output valid, output status, output crossing_time_q8, input ready);
   modport sink   (input valid, input status, input crossing_time_q8, output ready);
endinterface

FILE: rtl/cft_ram.sv
// generic single write port ram with registered read
module cft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/cft_div.sv
// restoring divider for the crossing fraction, one quotient bit per cycle
module cft_div import cft_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cft_div_req_type div_req,
   output cft_div_rsp_type div_rsp
);
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] dsh_ff, dsh_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [TW-1:0]    base_ff, base_in;
   logic [TW-1:0]    res_ff, res_in;
   logic             fit;

   assign fit = (rem_ff >= dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      base_in = base_ff;
      res_in  = res_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QW - 1);
         // dividend is 1280 times the magnitude
         rem_in  = (REM_W'(div_req.mag) << 10) + (REM_W'(div_req.mag) << 8);
         dsh_in  = REM_W'(div_req.den) << (QW - 1);
         q_in    = '0;
         base_in = div_req.base;
      end else if (busy_ff) begin
         rem_in = fit ? (rem_ff - dsh_ff) : rem_ff;
         q_in   = {q_ff[QW-2:0], fit};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            res_in  = base_ff + TW'(q_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      base_ff <= base_in;
      res_ff  <= res_in;
   end

   assign div_rsp.busy        = busy_ff;
   assign div_rsp.crossing_q8 = res_ff;
endmodule

FILE: rtl/constant_fraction_timing.sv
// top level of the constant fraction timing discriminator
//
// Samples of one trace enter on req_ch, one item per cycle while req_ch.ready
// is high, the final sample marked by last. A 32-entry delay ram supplies the
// delayed sample; the CFD value, arming test, five-sample sums and crossing
// test run in a four-stage pipeline. The first crossing of a trace starts the
// divider for the fractional time. One result item per trace leaves on rsp_ch
// from an output register, loaded once the last sample has left the pipeline
// and no division is running. From the acceptance of the last sample until
// the result is in the output register req_ch.ready is low.
// A stalled receiver holds the result and keeps req_ch.ready low once the
// next trace ends. Samples past the first 512 of a trace are ignored.
// Registers on the csr port are written at any edge with csr_we high. Reset
// clears the trace state and loads the register defaults: fraction -0.5,
// delay 10, threshold -50.
module constant_fraction_timing import cft_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   cft_req_if.sink              req_ch,
   cft_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata
);
   // configuration
   logic signed [SAMPLE_W-1:0] frac_ff, frac_in;
   logic        [DELAY_W-1:0]  delay_ff, delay_in;
   logic signed [SAMPLE_W-1:0] thr_ff, thr_in;

   // input side
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                accept, take;
   logic [ADDR_W-1:0]   raddr;
   logic [SAMPLE_W-1:0] rdata;
   logic                fwd_ff;
   logic [SAMPLE_W-1:0] fwd_data_ff;
   logic signed [SAMPLE_W-1:0] xd;
   logic signed [2*SAMPLE_W-1:0] prod;
   logic signed [CW-1:0] c_in;

   // stage a
   logic                 va_ff, ta_ff, la_ff;
   logic [IDX_W-1:0]     na_ff;
   logic signed [CW-1:0] ca_ff;

   // stage b
   logic                 vb_ff, tb_ff, lb_ff;
   logic [IDX_W-1:0]     nb_ff;
   logic signed [CW-1:0] hist_ff [HIST];
   logic                 armed_ff, armed_in;
   logic [IDX_W-1:0]     arm_at_ff, arm_at_in;

   // stage c
   logic                 vc_ff, tc_ff, lc_ff;
   logic [IDX_W-1:0]     nc_ff;
   logic signed [SW-1:0] s0_ff, s1_ff;
   logic signed [CW:0]   step_ff;

   // stage d
   logic signed [DIFF_W-1:0] diff, step5;
   logic                 hit;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     cross_at_ff, cross_at_in;
   logic                 fin_ff, fin_in;
   logic [IDX_W-1:0]     fin_len_ff, fin_len_in;
   cft_div_req_type      div_req;
   cft_div_rsp_type      div_rsp;

   // output
   logic                 load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [TW-1:0]        rsp_time_ff, rsp_time_in;

   // config port
   always_comb begin
      frac_in  = frac_ff;
      delay_in = delay_ff;
      thr_in   = thr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRACTION:  frac_in  = csr_wdata;
            CSR_DELAY:     delay_in = csr_wdata[DELAY_W-1:0];
            CSR_THRESHOLD: thr_in   = csr_wdata;
            default:       ;
         endcase
      end
   end

   // sample intake and delay line
   assign req_ch.ready = !pend_ff;
   assign accept       = req_ch.valid && !pend_ff;
   assign take         = (idx_ff < IDX_W'(TRACE_LEN));

   always_comb begin
      idx_in  = idx_ff;
      pend_in = pend_ff;
      if (accept) begin
         if (req_ch.last) begin
            idx_in  = '0;
            pend_in = 1'b1;
         end else if (take) begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
      if (load) begin
         pend_in = 1'b0;
      end
   end

   assign raddr = idx_in[ADDR_W-1:0] - ADDR_W'(delay_in);

   cft_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DELAY)) u_delay_ram (
      .clock (clock),
      .we    (accept && take),
      .waddr (idx_ff[ADDR_W-1:0]),
      .wdata (req_ch.sample),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      if (delay_ff == '0) begin
         xd = req_ch.sample;
      end else if (idx_ff < IDX_W'(delay_ff)) begin
         xd = '0;
      end else if (fwd_ff) begin
         xd = fwd_data_ff;
      end else begin
         xd = rdata;
      end
   end

   assign prod = (2*SAMPLE_W)'(frac_ff) * (2*SAMPLE_W)'(req_ch.sample);
   assign c_in = (CW'(xd) <<< FRAC_SH) + CW'(prod);

   // arming on stage a output
   always_comb begin
      armed_in  = armed_ff;
      arm_at_in = arm_at_ff;
      if (va_ff && ta_ff && !armed_ff && (na_ff >= IDX_W'(EDGE)) &&
          (ca_ff < (CW'(thr_ff) <<< FRAC_SH))) begin
         armed_in  = 1'b1;
         arm_at_in = na_ff;
      end
      if (load) begin
         armed_in = 1'b0;
      end
   end

   // crossing test on stage c output
   assign diff  = DIFF_W'(s1_ff) - DIFF_W'(s0_ff);
   assign step5 = (DIFF_W'(step_ff) <<< 2) + DIFF_W'(step_ff);
   assign hit   = vc_ff && tc_ff && armed_ff && !found_ff &&
                  (nc_ff >= IDX_W'(SPAN)) && ((nc_ff - IDX_W'(SPAN)) > arm_at_ff) &&
                  (s0_ff < 0) && (s1_ff > 0) && (diff > step5);

   assign div_req.start = hit;
   assign div_req.mag   = SW'(-s0_ff);
   assign div_req.den   = diff[DEN_W-1:0];
   assign div_req.base  = TW'({nc_ff - IDX_W'(SPAN + 2), {TIME_SH{1'b0}}});

   cft_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      found_in    = found_ff;
      cross_at_in = cross_at_ff;
      fin_in      = fin_ff;
      fin_len_in  = fin_len_ff;
      if (hit) begin
         found_in    = 1'b1;
         cross_at_in = nc_ff - IDX_W'(SPAN);
      end
      if (vc_ff && lc_ff) begin
         fin_in     = 1'b1;
         fin_len_in = nc_ff + IDX_W'(tc_ff);
      end
      if (load) begin
         found_in = 1'b0;
         fin_in   = 1'b0;
      end
   end

   // result register
   assign load = fin_ff && !div_rsp.busy && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_time_in   = rsp_time_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_time_in  = '0;
         if (found_ff && ({1'b0, cross_at_ff} + (IDX_W+1)'(11) <= {1'b0, fin_len_ff})) begin
            rsp_status_in = STATUS_FOUND;
            rsp_time_in   = div_rsp.crossing_q8;
         end else if (armed_ff &&
                      ({1'b0, arm_at_ff} + (IDX_W+1)'(11) <= {1'b0, fin_len_ff})) begin
            rsp_status_in = STATUS_NO_CROSS;
         end else begin
            rsp_status_in = STATUS_NEVER;
         end
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.crossing_time_q8 = rsp_time_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff      <= -16'sd8192;
         delay_ff     <= DELAY_W'(10);
         thr_ff       <= -16'sd50;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         armed_ff     <= 1'b0;
         arm_at_ff    <= '0;
         found_ff     <= 1'b0;
         cross_at_ff  <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frac_ff      <= frac_in;
         delay_ff     <= delay_in;
         thr_ff       <= thr_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         va_ff        <= accept;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         armed_ff     <= armed_in;
         arm_at_ff    <= arm_at_in;
         found_ff     <= found_in;
         cross_at_ff  <= cross_at_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      fwd_ff      <= accept && take && (idx_ff[ADDR_W-1:0] == raddr);
      fwd_data_ff <= req_ch.sample;

      ta_ff <= take;
      la_ff <= req_ch.last;
      na_ff <= idx_ff;
      ca_ff <= c_in;

      tb_ff <= ta_ff;
      lb_ff <= la_ff;
      nb_ff <= na_ff;
      if (va_ff && ta_ff) begin
         for (int i = 0; i < HIST - 1; i++) begin
            hist_ff[i] <= hist_ff[i+1];
         end
         hist_ff[HIST-1] <= ca_ff;
      end

      tc_ff   <= tb_ff;
      lc_ff   <= lb_ff;
      nc_ff   <= nb_ff;
      s0_ff   <= SW'(hist_ff[0]) + SW'(hist_ff[1]) + SW'(hist_ff[2]) +
                 SW'(hist_ff[3]) + SW'(hist_ff[4]);
      s1_ff   <= SW'(hist_ff[5]) + SW'(hist_ff[6]) + SW'(hist_ff[7]) +
                 SW'(hist_ff[8]) + SW'(hist_ff[9]);
      step_ff <= (CW+1)'(hist_ff[5]) - (CW+1)'(hist_ff[4]);

      fin_len_ff    <= fin_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_time_ff   <= rsp_time_in;
   end
endmodule
